// File: rtl/core/hrbd_pkg.sv
// Package for the HTTP response body deframer.
// Holds types, byte constants, result codes and lookup functions.
// No dependencies.
package hrbd_pkg;

  localparam int CHUNK_LEN_BITS_DEF = 32;
  localparam int PAT_LEN = 26;
  localparam int STATUS_MAX = 999;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] ERR_NONE          = 2'd0;
  localparam logic [1:0] ERR_NO_HEADER_END = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED     = 2'd2;

  typedef enum logic [1:0] {
    ST_WAIT_SPACE = 2'd0,
    ST_DIGITS     = 2'd1,
    ST_DONE       = 2'd2
  } status_phase_t;

  typedef enum logic [2:0] {
    CH_DIGITS = 3'd0,
    CH_REST   = 3'd1,
    CH_DATA   = 3'd2,
    CH_SKIP   = 3'd3,
    CH_DONE   = 3'd4
  } chunk_phase_t;

  typedef struct packed {
    logic step;
    logic eos;
  } hrbd_ctl_t;

  typedef struct packed {
    logic       in_body;
    logic       chunked;
    logic [9:0] status;
  } hrbd_hdr_t;

  typedef struct packed {
    logic emit;
    logic truncated;
  } hrbd_chk_t;

  function automatic logic [7:0] te_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd0:  ch = "t";
      5'd1:  ch = "r";
      5'd2:  ch = "a";
      5'd3:  ch = "n";
      5'd4:  ch = "s";
      5'd5:  ch = "f";
      5'd6:  ch = "e";
      5'd7:  ch = "r";
      5'd8:  ch = "-";
      5'd9:  ch = "e";
      5'd10: ch = "n";
      5'd11: ch = "c";
      5'd12: ch = "o";
      5'd13: ch = "d";
      5'd14: ch = "i";
      5'd15: ch = "n";
      5'd16: ch = "g";
      5'd17: ch = ":";
      5'd18: ch = " ";
      5'd19: ch = "c";
      5'd20: ch = "h";
      5'd21: ch = "u";
      5'd22: ch = "n";
      5'd23: ch = "k";
      5'd24: ch = "e";
      5'd25: ch = "d";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // bit 4 set when the byte is a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c inside {["0":"9"]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {["a":"f"], ["A":"F"]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/hrbd_in_if.sv
// Input channel of the deframer: one response byte or end of stream per word.
// Depends on nothing.
interface hrbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_stream;

  modport source (output valid, rx_byte, end_of_stream, input ready);
  modport sink (input valid, rx_byte, end_of_stream, output ready);
endinterface

// File: rtl/core/hrbd_out_if.sv
// Output channel of the deframer: one body byte or summary per word.
// Depends on nothing.
interface hrbd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] body_byte;
  logic [9:0] status_code;
  logic       was_chunked;
  logic [1:0] error_code;

  modport source (output valid, kind, body_byte, status_code, was_chunked, error_code,
                  input ready);
  modport sink (input valid, kind, body_byte, status_code, was_chunked, error_code,
                output ready);
endinterface

// File: rtl/core/hrbd_hdr.sv
// Header scanner: status code, transfer-encoding match and header end search.
// Depends on hrbd_pkg.
module hrbd_hdr (
  input  logic              clk,
  input  logic              rst,
  input  hrbd_pkg::hrbd_ctl_t ctl,
  input  logic [7:0]        rx_byte,
  output hrbd_pkg::hrbd_hdr_t hdr
);

  hrbd_pkg::status_phase_t status_phase, status_phase_next;
  logic [9:0]  status_value, status_value_next;
  logic [4:0]  pattern_progress, pattern_progress_next;
  logic        chunked_flag, chunked_flag_next;
  logic [1:0]  header_end_progress, header_end_progress_next;
  logic        in_body, in_body_next;
  logic [7:0]  lc;
  logic [13:0] scaled;
  logic        end_match;

  always_comb begin
    status_phase_next = status_phase;
    status_value_next = status_value;
    scaled = ({4'd0, status_value} << 3) + ({4'd0, status_value} << 1)
           + {10'd0, rx_byte[3:0]};
    case (status_phase)
      hrbd_pkg::ST_WAIT_SPACE: begin
        if (rx_byte == hrbd_pkg::CHAR_SPACE) status_phase_next = hrbd_pkg::ST_DIGITS;
      end
      hrbd_pkg::ST_DIGITS: begin
        if (rx_byte inside {["0":"9"]}) begin
          status_value_next = (scaled > 14'(hrbd_pkg::STATUS_MAX)) ?
                              10'(hrbd_pkg::STATUS_MAX) : scaled[9:0];
        end else begin
          status_phase_next = hrbd_pkg::ST_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    lc = (rx_byte inside {["A":"Z"]}) ? rx_byte + 8'd32 : rx_byte;
    pattern_progress_next = pattern_progress;
    chunked_flag_next = chunked_flag;
    header_end_progress_next = header_end_progress;
    in_body_next = in_body;
    end_match = (rx_byte == (header_end_progress[0] ? hrbd_pkg::CHAR_LF : hrbd_pkg::CHAR_CR));
    if (!in_body) begin
      if (pattern_progress != 5'(hrbd_pkg::PAT_LEN)) begin
        if (lc == hrbd_pkg::te_char(pattern_progress)) begin
          pattern_progress_next = pattern_progress + 5'd1;
        end else begin
          pattern_progress_next = (lc == hrbd_pkg::te_char(5'd0)) ? 5'd1 : 5'd0;
        end
        if (pattern_progress_next == 5'(hrbd_pkg::PAT_LEN)) chunked_flag_next = 1'b1;
      end
      if (end_match) begin
        header_end_progress_next = header_end_progress + 2'd1;
        if (header_end_progress == 2'd3) in_body_next = 1'b1;
      end else begin
        header_end_progress_next = (rx_byte == hrbd_pkg::CHAR_CR) ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (ctl.step && ctl.eos)) begin
      status_phase <= hrbd_pkg::ST_WAIT_SPACE;
      status_value <= '0;
      pattern_progress <= '0;
      chunked_flag <= 1'b0;
      header_end_progress <= '0;
      in_body <= 1'b0;
    end else if (ctl.step) begin
      status_phase <= status_phase_next;
      status_value <= status_value_next;
      pattern_progress <= pattern_progress_next;
      chunked_flag <= chunked_flag_next;
      header_end_progress <= header_end_progress_next;
      in_body <= in_body_next;
    end
  end

  assign hdr.in_body = in_body;
  assign hdr.chunked = chunked_flag;
  assign hdr.status = status_value;

endmodule

// File: rtl/core/hrbd_chunk.sv
// Chunk decoder: hex size line, data, two skipped bytes, stop on size zero.
// Depends on hrbd_pkg.
module hrbd_chunk #(
  parameter int CHUNK_LEN_BITS = hrbd_pkg::CHUNK_LEN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  hrbd_pkg::hrbd_ctl_t ctl,
  input  logic                active,
  input  logic [7:0]          rx_byte,
  output hrbd_pkg::hrbd_chk_t chk
);

  hrbd_pkg::chunk_phase_t phase, phase_next;
  logic [CHUNK_LEN_BITS-1:0] remaining, remaining_next;
  logic saw_cr, saw_cr_next;
  logic skip_count, skip_count_next;
  logic [4:0] hd;

  always_comb begin
    phase_next = phase;
    remaining_next = remaining;
    saw_cr_next = saw_cr;
    skip_count_next = skip_count;
    hd = hrbd_pkg::hex_digit(rx_byte);
    case (phase)
      hrbd_pkg::CH_DIGITS: begin
        if (hd[4]) begin
          if (remaining[CHUNK_LEN_BITS-1 -: 4] != 4'd0) begin
            remaining_next = '1;
          end else begin
            remaining_next = {remaining[CHUNK_LEN_BITS-5:0], hd[3:0]};
          end
        end else begin
          phase_next = hrbd_pkg::CH_REST;
          saw_cr_next = (rx_byte == hrbd_pkg::CHAR_CR);
        end
      end
      hrbd_pkg::CH_REST: begin
        if (saw_cr && rx_byte == hrbd_pkg::CHAR_LF) begin
          saw_cr_next = 1'b0;
          phase_next = (remaining == '0) ? hrbd_pkg::CH_DONE : hrbd_pkg::CH_DATA;
        end else begin
          saw_cr_next = (rx_byte == hrbd_pkg::CHAR_CR);
        end
      end
      hrbd_pkg::CH_DATA: begin
        remaining_next = remaining - {{(CHUNK_LEN_BITS-1){1'b0}}, 1'b1};
        if (remaining_next == '0) begin
          phase_next = hrbd_pkg::CH_SKIP;
          skip_count_next = 1'b0;
        end
      end
      hrbd_pkg::CH_SKIP: begin
        if (skip_count) begin
          skip_count_next = 1'b0;
          phase_next = hrbd_pkg::CH_DIGITS;
          remaining_next = '0;
        end else begin
          skip_count_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    chk.emit = (phase == hrbd_pkg::CH_DATA);
    chk.truncated = (phase == hrbd_pkg::CH_DATA) && (remaining != '0);
  end

  always_ff @(posedge clk) begin
    if (rst || (ctl.step && ctl.eos)) begin
      phase <= hrbd_pkg::CH_DIGITS;
      remaining <= '0;
      saw_cr <= 1'b0;
      skip_count <= 1'b0;
    end else if (ctl.step && active) begin
      phase <= phase_next;
      remaining <= remaining_next;
      saw_cr <= saw_cr_next;
      skip_count <= skip_count_next;
    end
  end

endmodule

// File: rtl/core/http_response_body_deframer_top.sv
// Top level of the HTTP response body deframer.
// Depends on hrbd_pkg, hrbd_in_if, hrbd_out_if, hrbd_hdr and hrbd_chunk.
//
//   port | dir | word carries
//   rx   | in  | rx_byte, end_of_stream
//   tx   | out | kind, body_byte, status_code, was_chunked, error_code
//
// One word per cycle in while tx does not stall, at most one word out per input word.
// tx valid is registered: a word passes the input register, then the result register.
// State advances as a word leaves the input register; end_of_stream returns it to reset.
// rst is synchronous and clears control state; tx stalls back up into rx.ready.
module http_response_body_deframer_top #(
  parameter int CHUNK_LEN_BITS = hrbd_pkg::CHUNK_LEN_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  hrbd_in_if.sink    rx,
  hrbd_out_if.source tx
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       advance;
  logic       produce;
  hrbd_pkg::hrbd_ctl_t ctl;
  hrbd_pkg::hrbd_hdr_t hdr;
  hrbd_pkg::hrbd_chk_t chk;

  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_byte;
  logic [9:0] out_status;
  logic       out_chunked;
  logic [1:0] out_err;

  assign advance = in_valid && (!out_valid || tx.ready);
  assign rx.ready = !in_valid || advance;
  assign ctl.step = advance;
  assign ctl.eos = in_eos;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
      in_eos <= rx.end_of_stream;
    end
  end

  hrbd_hdr u_hdr (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rx_byte (in_byte),
    .hdr     (hdr)
  );

  hrbd_chunk #(
    .CHUNK_LEN_BITS (CHUNK_LEN_BITS)
  ) u_chunk (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .active  (hdr.in_body && hdr.chunked),
    .rx_byte (in_byte),
    .chk     (chk)
  );

  assign produce = in_eos || (hdr.in_body && (!hdr.chunked || chk.emit));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || tx.ready) begin
      out_valid <= in_valid && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_eos) begin
        out_kind <= hrbd_pkg::KIND_SUMMARY;
        out_byte <= 8'd0;
        out_status <= hdr.status;
        out_chunked <= hdr.chunked;
        if (!hdr.in_body) begin
          out_err <= hrbd_pkg::ERR_NO_HEADER_END;
        end else if (hdr.chunked && chk.truncated) begin
          out_err <= hrbd_pkg::ERR_TRUNCATED;
        end else begin
          out_err <= hrbd_pkg::ERR_NONE;
        end
      end else begin
        out_kind <= hrbd_pkg::KIND_BODY;
        out_byte <= in_byte;
        out_status <= 10'd0;
        out_chunked <= 1'b0;
        out_err <= hrbd_pkg::ERR_NONE;
      end
    end
  end

  assign tx.valid = out_valid;
  assign tx.kind = out_kind;
  assign tx.body_byte = out_byte;
  assign tx.status_code = out_status;
  assign tx.was_chunked = out_chunked;
  assign tx.error_code = out_err;

endmodule

// File: bench/tb_deframer_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the HTTP response body deframer bench: predicts output words
// from accepted input words and checks each output word in order.
// Depends on hrbd_pkg.
package tb_deframer_sb_pkg;
  import hrbd_pkg::*;

  localparam int LEN_W = CHUNK_LEN_BITS_DEF;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic       kind;
    logic [7:0] body_byte;
    logic [9:0] status_code;
    logic       was_chunked;
    logic [1:0] error_code;
  } deframer_word_t;

  class deframe_scoreboard;
    deframer_word_t awaited_words[$];
    int fails;
    int body_seen;
    int summary_seen;

    logic [2:0]       crlf_seen;
    logic             in_body;
    status_phase_t    st_phase;
    logic [9:0]       status_val;
    logic [4:0]       te_seen;
    logic             chunked;
    chunk_phase_t     ck_phase;
    logic [LEN_W-1:0] chunk_left;
    logic             cr_pending;
    logic [1:0]       skip_cnt;
    string            te_text;

    function new();
      te_text = "transfer-encoding: chunked";
      fails = 0;
      body_seen = 0;
      summary_seen = 0;
      restart();
    endfunction

    function void restart();
      crlf_seen = '0;
      in_body = 1'b0;
      st_phase = ST_WAIT_SPACE;
      status_val = '0;
      te_seen = '0;
      chunked = 1'b0;
      ck_phase = CH_DIGITS;
      chunk_left = '0;
      cr_pending = 1'b0;
      skip_cnt = '0;
    endfunction

    function int pending();
      return awaited_words.size();
    endfunction

    function void note_input(logic [7:0] c, logic eos);
      deframer_word_t w;
      logic [7:0] lc;
      int v;
      int d;
      bit emit;
      w = '0;
      if (eos) begin
        w.kind = KIND_SUMMARY;
        w.status_code = status_val;
        w.was_chunked = chunked;
        if (!in_body) begin
          w.error_code = ERR_NO_HEADER_END;
        end else if (chunked && ck_phase == CH_DATA && chunk_left != 0) begin
          w.error_code = ERR_TRUNCATED;
        end else begin
          w.error_code = ERR_NONE;
        end
        awaited_words.push_back(w);
        restart();
        return;
      end

      case (st_phase)
        ST_WAIT_SPACE: begin
          if (c == CHAR_SPACE) st_phase = ST_DIGITS;
        end
        ST_DIGITS: begin
          if (c >= "0" && c <= "9") begin
            v = status_val * 10 + (c - "0");
            status_val = (v > STATUS_MAX) ? 10'(STATUS_MAX) : 10'(v);
          end else begin
            st_phase = ST_DONE;
          end
        end
        default: ;
      endcase

      if (!in_body) begin
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (te_seen < PAT_LEN) begin
          if (lc == te_text[te_seen]) te_seen++;
          else te_seen = (lc == te_text[0]) ? 5'd1 : 5'd0;
          if (te_seen == PAT_LEN) chunked = 1'b1;
        end
        if (c == (crlf_seen[0] ? CHAR_LF : CHAR_CR)) crlf_seen++;
        else crlf_seen = (c == CHAR_CR) ? 3'd1 : 3'd0;
        if (crlf_seen >= 3'd4) begin
          crlf_seen = '0;
          in_body = 1'b1;
        end
        return;
      end

      emit = 1'b1;
      if (chunked) begin
        emit = 1'b0;
        case (ck_phase)
          CH_DIGITS: begin
            d = -1;
            if (c >= "0" && c <= "9") d = c - "0";
            else if (c >= "a" && c <= "f") d = c - "a" + 10;
            else if (c >= "A" && c <= "F") d = c - "A" + 10;
            if (d >= 0) begin
              if (chunk_left > (LEN_MAX >> 4)) chunk_left = LEN_MAX;
              else chunk_left = {chunk_left[LEN_W-5:0], 4'(d)};
            end else begin
              ck_phase = CH_REST;
              cr_pending = (c == CHAR_CR);
            end
          end
          CH_REST: begin
            if (cr_pending && c == CHAR_LF) begin
              cr_pending = 1'b0;
              if (chunk_left == 0) ck_phase = CH_DONE;
              else ck_phase = CH_DATA;
            end else begin
              cr_pending = (c == CHAR_CR);
            end
          end
          CH_DATA: begin
            chunk_left--;
            if (chunk_left == 0) begin
              ck_phase = CH_SKIP;
              skip_cnt = '0;
            end
            emit = 1'b1;
          end
          CH_SKIP: begin
            if (skip_cnt >= 2'd1) begin
              skip_cnt = '0;
              ck_phase = CH_DIGITS;
              chunk_left = '0;
            end else begin
              skip_cnt++;
            end
          end
          default: ;
        endcase
      end
      if (emit) begin
        w.kind = KIND_BODY;
        w.body_byte = c;
        awaited_words.push_back(w);
      end
    endfunction

    function void field_check(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_word(deframer_word_t got);
      deframer_word_t want;
      if (awaited_words.size() == 0) begin
        $error("output word with nothing awaited: kind %0d body_byte %0d", got.kind,
               got.body_byte);
        fails++;
        return;
      end
      want = awaited_words.pop_front();
      if (want.kind == KIND_BODY) body_seen++;
      else summary_seen++;
      field_check("kind", want.kind, got.kind);
      field_check("body_byte", want.body_byte, got.body_byte);
      field_check("status_code", want.status_code, got.status_code);
      field_check("was_chunked", want.was_chunked, got.was_chunked);
      field_check("error_code", want.error_code, got.error_code);
    endfunction
  endclass

endpackage

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Bench top for http_response_body_deframer_top: feeds directed and random
// HTTP responses with random gaps and stalls, checks output words in order.
// Depends on hrbd_pkg, hrbd_in_if, hrbd_out_if and tb_deframer_sb_pkg.
module tb_top;
  import hrbd_pkg::*;
  import tb_deframer_sb_pkg::*;

  localparam int RANDOM_WORDS = 1100;
  localparam int STALL_MAX = 11;
  localparam int DRAIN_CYCLES = 8;
  localparam string CRLF = "\015\012";

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic out_steady = 1'b0;
  bit in_steady;
  int stall_left;
  int out_pause;
  int words_sent;
  int responses;
  int directed_words;
  logic [7:0] resp_bytes[$];
  deframer_word_t seen_word;
  deframe_scoreboard sb;

  hrbd_in_if rx_if();
  hrbd_out_if tx_if();

  http_response_body_deframer_top u_dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_if),
    .tx (tx_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      tx_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (tx_if.valid && tx_if.ready) begin
      seen_word.kind = tx_if.kind;
      seen_word.body_byte = tx_if.body_byte;
      seen_word.status_code = tx_if.status_code;
      seen_word.was_chunked = tx_if.was_chunked;
      seen_word.error_code = tx_if.error_code;
      sb.check_word(seen_word);
      out_pause = out_steady ? 0 : $urandom_range(0, STALL_MAX);
      if (out_pause > 0) begin
        tx_if.ready <= 1'b0;
        stall_left <= out_pause;
      end
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      tx_if.ready <= 1'b1;
    end
  end

  function automatic void push_text(input string s, input bit mix = 1'b0);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (mix && (ch | 8'h20) >= "a" && (ch | 8'h20) <= "z" && $urandom_range(0, 1))
        ch = ch ^ 8'h20;
      resp_bytes.push_back(ch);
    end
  endfunction

  function automatic void push_noise(input int n);
    repeat (n) resp_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_header_line();
    push_text("X-Tag: ");
    if ($urandom_range(0, 1)) push_noise($urandom_range(1, 6));
    else push_text("keep-alive", 1'b1);
    if ($urandom_range(0, 5) == 0) push_text({"\015", CRLF});
    else push_text(CRLF);
  endfunction

  function automatic void build_response();
    int size;
    bit chunked;
    resp_bytes.delete();
    if ($urandom_range(0, 15) == 0) begin
      push_noise($urandom_range(0, 30));
      return;
    end

    if ($urandom_range(0, 7) == 0) push_noise($urandom_range(1, 3));
    push_text("HTTP/1.1 ");
    case ($urandom_range(0, 7))
      0: push_text("+");
      1: push_text("-");
      default: ;
    endcase
    repeat ($urandom_range(0, 5)) push_text($sformatf("%0d", $urandom_range(0, 9)));
    case ($urandom_range(0, 5))
      0: push_text("x");
      1: push_text("-");
      default: ;
    endcase
    push_text({" OK", CRLF});

    chunked = ($urandom_range(0, 2) != 0);
    repeat ($urandom_range(0, 2)) push_header_line();
    if (chunked) begin
      if ($urandom_range(0, 3) == 0) push_text("t");
      push_text({"transfer-encoding: chunked", CRLF}, 1'b1);
    end else if ($urandom_range(0, 3) == 0) begin
      push_text({"Transfer-Encoding: chunk", CRLF}, 1'b1);
    end
    repeat ($urandom_range(0, 2)) push_header_line();

    if ($urandom_range(0, 11) == 0) begin
      push_noise($urandom_range(0, 8));
      return;
    end
    push_text(CRLF);

    if (!chunked) begin
      push_noise($urandom_range(0, 16));
      return;
    end

    repeat ($urandom_range(0, 4)) begin
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      case ($urandom_range(0, 19))
        0: push_text("0x");
        1: push_text("+");
        2: push_text(CRLF);
        3: push_text("00");
        4: begin
          push_text({"1fffffffff", CRLF}, 1'b1);
          push_noise($urandom_range(1, 6));
          return;
        end
        default: ;
      endcase
      push_text($sformatf("%0h", size), 1'b1);
      case ($urandom_range(0, 7))
        0: push_text(";ext=1");
        1: push_text(" \015z");
        2: push_text("\015z");
        default: ;
      endcase
      push_text(CRLF);
      push_noise(size);
      if ($urandom_range(0, 5) == 0) push_noise(2);
      else push_text(CRLF);
    end

    case ($urandom_range(0, 5))
      0: begin
        push_text({"5", CRLF});
        push_noise($urandom_range(0, 4));
      end
      1: push_text("1");
      2: push_text({"2", CRLF, "ab"});
      default: begin
        push_text({"0", CRLF});
        if ($urandom_range(0, 1)) push_text({"X-Trailer: 1", CRLF});
        push_text(CRLF);
        if ($urandom_range(0, 3) == 0) push_noise($urandom_range(1, 5));
      end
    endcase
  endfunction

  task automatic send_word(input logic [7:0] b, input logic eos);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    rx_if.end_of_stream <= eos;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    sb.note_input(b, eos);
    words_sent++;
  endtask

  task automatic send_response();
    foreach (resp_bytes[i]) send_word(resp_bytes[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
    responses++;
    in_steady = ($urandom_range(0, 4) == 0);
    out_steady <= ($urandom_range(0, 4) == 0);
  endtask

  initial begin
    sb = new();
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    rx_if.end_of_stream = 1'b0;
    in_steady = 1'b0;
    words_sent = 0;
    responses = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    resp_bytes.delete();
    send_response();
    resp_bytes.delete();
    push_text({" 1234", CRLF, CRLF});
    resp_bytes.push_back(8'h00);
    resp_bytes.push_back(8'hFF);
    send_response();
    resp_bytes.delete();
    push_text({" -2", CRLF});
    send_response();
    directed_words = words_sent;

    while (words_sent < directed_words + RANDOM_WORDS) begin
      build_response();
      send_response();
    end

    rx_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d responses in %0d input words", responses, words_sent);
    $display("Checked %0d body bytes and %0d end-of-response summaries",
             sb.body_seen, sb.summary_seen);
    if (sb.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
